/* sv/emacv_pkg.sv */
// Shared types, constants and arithmetic helpers of the covariance tracker.
`default_nettype none

package emacv_pkg;

   // Geometry and widths.
   localparam int NUM_FEATURES = 4;
   localparam int IDX_W        = 2;
   localparam int DATA_W       = 32;
   localparam int OPD_W        = 33;
   localparam int PROD_W       = 66;
   localparam int STD_W        = 24;
   localparam int SQRT_IN_W    = 48;
   localparam int DIV_W        = 56;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int CNT_W        = 8;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIANCE_FLOOR   = 2'd2;

   // Reset values.
   localparam logic [15:0]      LR_RESET       = 16'd655;
   localparam logic [CNT_W-1:0] INTERVAL_RESET = 8'd20;
   localparam logic [15:0]      FLOOR_RESET    = 16'd1;
   localparam logic [STD_W-1:0] STD_RESET      = 24'd256;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_UPDATED   = 2'd0,
      STAT_SKIPPED   = 2'd1,
      STAT_NOT_READY = 2'd2,
      STAT_LOADED    = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_SQ,
      ST_LD_WR,
      ST_M_MUL,
      ST_M_WR,
      ST_V_SQ,
      ST_V_SQW,
      ST_V_MUL,
      ST_V_WR,
      ST_SQRT,
      ST_SQRT_W,
      ST_DIV,
      ST_DIV_W,
      ST_C_ZZ,
      ST_C_ZZW,
      ST_C_MUL,
      ST_C_WR,
      ST_COUNT,
      ST_EMIT
   } state_type;

   // Divide by 2^s, rounding half away from zero.
   function automatic logic signed [PROD_W-1:0] rnd_shr(
      input logic signed [PROD_W-1:0] v,
      input logic [4:0]                s
   );
      logic                    neg;
      logic [PROD_W-1:0]       mag;
      logic [PROD_W-1:0]       r;
      neg = v[PROD_W-1];
      mag = neg ? PROD_W'(-v) : PROD_W'(v);
      r   = (mag + (PROD_W'(1) << (s - 5'd1))) >> s;
      return neg ? -$signed(r) : $signed(r);
   endfunction

   // Saturate to 32 bits signed.
   function automatic logic signed [DATA_W-1:0] sat32(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(64'sd2147483647);
      lo = PROD_W'(-64'sd2147483648);
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/emacv_ifs.sv */
// Channel interfaces of the covariance tracker: request, result and control writes.
`default_nettype none

interface emacv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic                                   is_normal;
   logic signed [emacv_pkg::DATA_W-1:0]    feature_0;
   logic signed [emacv_pkg::DATA_W-1:0]    feature_1;
   logic signed [emacv_pkg::DATA_W-1:0]    feature_2;
   logic signed [emacv_pkg::DATA_W-1:0]    feature_3;
   logic [emacv_pkg::IDX_W-1:0]            row_index;
   logic signed [emacv_pkg::DATA_W-1:0]    init_mean;
   logic [emacv_pkg::DATA_W-1:0]           init_std;

   modport source (output valid, func, is_normal, feature_0, feature_1, feature_2,
                   feature_3, row_index, init_mean, init_std, input ready);
   modport sink (input valid, func, is_normal, feature_0, feature_1, feature_2,
                 feature_3, row_index, init_mean, init_std, output ready);
endinterface

interface emacv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             status;
   logic [emacv_pkg::IDX_W-1:0]            row_number;
   logic signed [emacv_pkg::DATA_W-1:0]    mean_value;
   logic [emacv_pkg::DATA_W-1:0]           std_dev;
   logic signed [emacv_pkg::DATA_W-1:0]    cov_0;
   logic signed [emacv_pkg::DATA_W-1:0]    cov_1;
   logic signed [emacv_pkg::DATA_W-1:0]    cov_2;
   logic signed [emacv_pkg::DATA_W-1:0]    cov_3;
   logic                                   inverse_due;
   logic                                   last;

   modport source (output valid, status, row_number, mean_value, std_dev, cov_0, cov_1,
                   cov_2, cov_3, inverse_due, last, input ready);
   modport sink (input valid, status, row_number, mean_value, std_dev, cov_0, cov_1,
                 cov_2, cov_3, inverse_due, last, output ready);
endinterface

interface emacv_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [emacv_pkg::CSR_IDX_W-1:0]        index;
   logic [emacv_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/ema_mean_variance_covariance_tracker.sv */
// Top level of the adaptive mean, variance and standardized covariance tracker.
`default_nettype none

// A load request writes one feature row and gives one result. A sample request, once all
// four rows are loaded and the status is normal, gives four results, one per row; a sample
// that is skipped or not ready gives one result on the next cycle.
// The sample time is set by one shared 33x33 multiplier, a 24-step square root (once per
// row) and a 56-step divider (once per row), all run in turn by one sequencer; the block
// takes no request until the last result of the previous one has been taken.
module ema_mean_variance_covariance_tracker (
   input  wire logic     clock,
   input  wire logic     reset,
   emacv_req_if.sink     req_ch,
   emacv_rsp_if.source   rsp_ch,
   emacv_csr_if.sink     csr_ch
);

   localparam int NF = emacv_pkg::NUM_FEATURES;
   localparam int DW = emacv_pkg::DATA_W;
   localparam int PW = emacv_pkg::PROD_W;
   localparam int OW = emacv_pkg::OPD_W;
   localparam int IW = emacv_pkg::IDX_W;

   // Sequencer and control state.
   emacv_pkg::state_type              state_ff, state_in;
   emacv_pkg::status_type             status_ff, status_in;
   logic [IW-1:0]                     i_ff, i_in;
   logic [IW-1:0]                     j_ff, j_in;
   logic                              func_ff, func_in;
   logic                              due_ff, due_in;
   logic [emacv_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NF-1:0]                     rows_ff, rows_in;
   logic                              rdy_ff, rdy_in;

   // Control registers.
   logic [15:0]                       lr_ff;
   logic [emacv_pkg::CNT_W-1:0]       intv_ff;
   logic [15:0]                       floor_ff;

   // Request payload.
   logic signed [DW-1:0]              x_ff [NF];
   logic signed [DW-1:0]              imean_ff;
   logic [DW-1:0]                     isd_ff;

   // Tracked statistics and work values.
   logic signed [DW-1:0]              means_ff [NF];
   logic [DW-1:0]                     var_ff [NF];
   logic [emacv_pkg::STD_W-1:0]       std_ff [NF];
   logic signed [DW-1:0]              cov_ff [NF][NF];
   logic signed [OW-1:0]              diff_ff [NF];
   logic signed [DW-1:0]              zs_ff [NF];
   logic signed [OW-1:0]              tmp_ff, tmp_in;

   // Write strobes and data.
   logic                              mean_we, var_we, std_we, cov_we, row_we;
   logic                              diff_we, zs_we, tmp_we;
   logic signed [DW-1:0]              mean_in, cov_in, zs_in;
   logic [DW-1:0]                     var_in;

   // Shared units.
   logic signed [OW-1:0]              mul_a, mul_b;
   logic signed [PW-1:0]              prod;
   logic                              sqrt_start, sqrt_done;
   logic [emacv_pkg::STD_W-1:0]       sqrt_root;
   logic                              div_start, div_done;
   logic [emacv_pkg::DIV_W-1:0]       div_num, div_q;

   // Datapath helpers.
   logic                              req_acc, rsp_acc, last_i, last_j, fill, rsp_last;
   logic signed [OW-1:0]              lr_ext, d_cur, d_abs;
   logic signed [PW-1:0]              p_r16, p_r24, sq_wide, var_sum, floor_ext;
   logic [DW-1:0]                     sq_sat;
   logic [15:0]                       eff_floor;
   logic signed [DW-1:0]              ic;
   logic [DW-1:0]                     dmag;
   logic                              q_big;
   logic [emacv_pkg::CNT_W-1:0]       cnt_plus;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
   assign last_i  = (i_ff == IW'(NF - 1));
   assign last_j  = (j_ff == IW'(NF - 1));
   assign rsp_last = (status_ff != emacv_pkg::STAT_UPDATED) || last_i;

   // Control register writes.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= emacv_pkg::LR_RESET;
         intv_ff  <= emacv_pkg::INTERVAL_RESET;
         floor_ff <= emacv_pkg::FLOOR_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            emacv_pkg::CSR_LEARNING_RATE:    lr_ff    <= csr_ch.data;
            emacv_pkg::CSR_INVERSE_INTERVAL: intv_ff  <= csr_ch.data[emacv_pkg::CNT_W-1:0];
            emacv_pkg::CSR_VARIANCE_FLOOR:   floor_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Arithmetic around the shared multiplier.
   always_comb begin
      lr_ext    = {17'b0, lr_ff};
      d_cur     = OW'(x_ff[i_ff]) - OW'(means_ff[i_ff]);
      d_abs     = d_cur[OW-1] ? -d_cur : d_cur;
      p_r16     = emacv_pkg::rnd_shr(prod, 5'd16);
      p_r24     = emacv_pkg::rnd_shr(prod, 5'd24);
      sq_wide   = (prod + PW'(32'sh8000)) >>> 16;
      sq_sat    = (sq_wide[PW-1:DW] != '0) ? '1 : sq_wide[DW-1:0];
      ic        = emacv_pkg::sat32(p_r24);
      eff_floor = (floor_ff == 16'd0) ? 16'd1 : floor_ff;
      floor_ext = PW'({16'b0, eff_floor});
      mean_in   = (state_ff == emacv_pkg::ST_LD_WR) ? imean_ff
                  : emacv_pkg::sat32(PW'(means_ff[i_ff]) + p_r16);
      var_sum   = (state_ff == emacv_pkg::ST_LD_WR) ? PW'({1'b0, sq_sat})
                  : PW'({1'b0, var_ff[i_ff]}) + p_r16;
      if (var_sum > PW'({1'b0, 32'hFFFFFFFF})) begin
         var_in = '1;
      end else if (var_sum < floor_ext) begin
         var_in = {16'b0, eff_floor};
      end else begin
         var_in = var_sum[DW-1:0];
      end
      cov_in    = emacv_pkg::sat32(PW'(cov_ff[i_ff][j_ff]) + p_r16);
      tmp_in    = (state_ff == emacv_pkg::ST_V_SQW) ? OW'({1'b0, sq_sat}) : OW'(ic);
      cnt_plus  = cnt_ff + 8'd1;
      // Standardized distance from the divider, clipped to 32 bits signed.
      dmag      = diff_ff[i_ff][OW-1] ? DW'(-diff_ff[i_ff]) : DW'(diff_ff[i_ff]);
      div_num   = {dmag, 24'b0} + emacv_pkg::DIV_W'(std_ff[i_ff] >> 1);
      q_big     = (div_q[emacv_pkg::DIV_W-1:DW-1] != '0);
      if (diff_ff[i_ff][OW-1]) begin
         zs_in = q_big ? 32'sh80000000 : -$signed(div_q[DW-1:0]);
      end else begin
         zs_in = q_big ? 32'sh7FFFFFFF : $signed(div_q[DW-1:0]);
      end
   end

   // Multiplier operand selection.
   always_comb begin
      case (state_ff)
         emacv_pkg::ST_LD_SQ: begin
            mul_a = OW'({1'b0, isd_ff});
            mul_b = OW'({1'b0, isd_ff});
         end
         emacv_pkg::ST_M_MUL: begin
            mul_a = lr_ext;
            mul_b = d_cur;
         end
         emacv_pkg::ST_V_SQ: begin
            mul_a = d_abs;
            mul_b = d_abs;
         end
         emacv_pkg::ST_V_MUL: begin
            mul_a = lr_ext;
            mul_b = tmp_ff - OW'({1'b0, var_ff[i_ff]});
         end
         emacv_pkg::ST_C_ZZ: begin
            mul_a = OW'(zs_ff[i_ff]);
            mul_b = OW'(zs_ff[j_ff]);
         end
         emacv_pkg::ST_C_MUL: begin
            mul_a = lr_ext;
            mul_b = tmp_ff - OW'(cov_ff[i_ff][j_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   emacv_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   emacv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({var_ff[i_ff], 16'b0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   emacv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (std_ff[i_ff]),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         emacv_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.func) begin
                  state_in = emacv_pkg::ST_LD_SQ;
               end else if (!rdy_ff || !req_ch.is_normal) begin
                  state_in = emacv_pkg::ST_EMIT;
               end else begin
                  state_in = emacv_pkg::ST_M_MUL;
               end
            end
         end
         emacv_pkg::ST_LD_SQ:  state_in = emacv_pkg::ST_LD_WR;
         emacv_pkg::ST_LD_WR:  state_in = emacv_pkg::ST_SQRT;
         emacv_pkg::ST_M_MUL:  state_in = emacv_pkg::ST_M_WR;
         emacv_pkg::ST_M_WR:   state_in = last_i ? emacv_pkg::ST_V_SQ : emacv_pkg::ST_M_MUL;
         emacv_pkg::ST_V_SQ:   state_in = emacv_pkg::ST_V_SQW;
         emacv_pkg::ST_V_SQW:  state_in = emacv_pkg::ST_V_MUL;
         emacv_pkg::ST_V_MUL:  state_in = emacv_pkg::ST_V_WR;
         emacv_pkg::ST_V_WR:   state_in = emacv_pkg::ST_SQRT;
         emacv_pkg::ST_SQRT:   state_in = emacv_pkg::ST_SQRT_W;
         emacv_pkg::ST_SQRT_W: begin
            if (sqrt_done) begin
               if (func_ff) begin
                  state_in = emacv_pkg::ST_EMIT;
               end else begin
                  state_in = last_i ? emacv_pkg::ST_DIV : emacv_pkg::ST_V_SQ;
               end
            end
         end
         emacv_pkg::ST_DIV:    state_in = emacv_pkg::ST_DIV_W;
         emacv_pkg::ST_DIV_W: begin
            if (div_done) begin
               state_in = last_i ? emacv_pkg::ST_C_ZZ : emacv_pkg::ST_DIV;
            end
         end
         emacv_pkg::ST_C_ZZ:   state_in = emacv_pkg::ST_C_ZZW;
         emacv_pkg::ST_C_ZZW:  state_in = emacv_pkg::ST_C_MUL;
         emacv_pkg::ST_C_MUL:  state_in = emacv_pkg::ST_C_WR;
         emacv_pkg::ST_C_WR: begin
            state_in = (last_i && last_j) ? emacv_pkg::ST_COUNT : emacv_pkg::ST_C_ZZ;
         end
         emacv_pkg::ST_COUNT:  state_in = emacv_pkg::ST_EMIT;
         emacv_pkg::ST_EMIT: begin
            if (rsp_acc && rsp_last) begin
               state_in = emacv_pkg::ST_IDLE;
            end
         end
         default: state_in = emacv_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: strobes, counters and bookkeeping.
   always_comb begin
      mean_we    = 1'b0;
      var_we     = 1'b0;
      std_we     = 1'b0;
      cov_we     = 1'b0;
      row_we     = 1'b0;
      diff_we    = 1'b0;
      zs_we      = 1'b0;
      tmp_we     = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      i_in       = i_ff;
      j_in       = j_ff;
      status_in  = status_ff;
      func_in    = func_ff;
      due_in     = due_ff;
      cnt_in     = cnt_ff;
      rows_in    = rows_ff;
      rdy_in     = rdy_ff;
      case (state_ff)
         emacv_pkg::ST_IDLE: begin
            if (req_acc) begin
               func_in = req_ch.func;
               due_in  = 1'b0;
               j_in    = '0;
               i_in    = req_ch.func ? req_ch.row_index : '0;
               if (req_ch.func) begin
                  status_in = emacv_pkg::STAT_LOADED;
               end else if (!rdy_ff) begin
                  status_in = emacv_pkg::STAT_NOT_READY;
               end else if (!req_ch.is_normal) begin
                  status_in = emacv_pkg::STAT_SKIPPED;
               end else begin
                  status_in = emacv_pkg::STAT_UPDATED;
               end
            end
         end
         emacv_pkg::ST_LD_WR: begin
            mean_we = 1'b1;
            var_we  = 1'b1;
            row_we  = 1'b1;
            rows_in = rows_ff | (NF'(1) << i_ff);
            rdy_in  = rdy_ff || ((rows_ff | (NF'(1) << i_ff)) == '1);
            cnt_in  = '0;
         end
         emacv_pkg::ST_M_WR: begin
            mean_we = 1'b1;
            i_in    = i_ff + IW'(1);
         end
         emacv_pkg::ST_V_SQ: begin
            diff_we = 1'b1;
         end
         emacv_pkg::ST_V_SQW: begin
            tmp_we = 1'b1;
         end
         emacv_pkg::ST_V_WR: begin
            var_we = 1'b1;
         end
         emacv_pkg::ST_SQRT: begin
            sqrt_start = 1'b1;
         end
         emacv_pkg::ST_SQRT_W: begin
            if (sqrt_done) begin
               std_we = 1'b1;
               if (!func_ff) begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         emacv_pkg::ST_DIV: begin
            div_start = 1'b1;
         end
         emacv_pkg::ST_DIV_W: begin
            if (div_done) begin
               zs_we = 1'b1;
               i_in  = i_ff + IW'(1);
            end
         end
         emacv_pkg::ST_C_ZZW: begin
            tmp_we = 1'b1;
         end
         emacv_pkg::ST_C_WR: begin
            cov_we = 1'b1;
            j_in   = j_ff + IW'(1);
            if (last_j) begin
               i_in = i_ff + IW'(1);
            end
         end
         emacv_pkg::ST_COUNT: begin
            i_in = '0;
            if (cnt_plus >= intv_ff) begin
               due_in = 1'b1;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_plus;
            end
         end
         emacv_pkg::ST_EMIT: begin
            if (rsp_acc && !rsp_last) begin
               i_in = i_ff + IW'(1);
            end
         end
         default: ;
      endcase
   end

   // Control registers of the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= emacv_pkg::ST_IDLE;
         status_ff <= emacv_pkg::STAT_UPDATED;
         i_ff      <= '0;
         j_ff      <= '0;
         func_ff   <= 1'b0;
         due_ff    <= 1'b0;
         cnt_ff    <= '0;
         rows_ff   <= '0;
         rdy_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         func_ff   <= func_in;
         due_ff    <= due_in;
         cnt_ff    <= cnt_in;
         rows_ff   <= rows_in;
         rdy_ff    <= rdy_in;
      end
   end

   // Request capture and work values.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff[0]  <= req_ch.feature_0;
         x_ff[1]  <= req_ch.feature_1;
         x_ff[2]  <= req_ch.feature_2;
         x_ff[3]  <= req_ch.feature_3;
         imean_ff <= req_ch.init_mean;
         isd_ff   <= req_ch.init_std;
      end
      if (diff_we) begin
         diff_ff[i_ff] <= d_cur;
      end
      if (zs_we) begin
         zs_ff[i_ff] <= zs_in;
      end
      if (tmp_we) begin
         tmp_ff <= tmp_in;
      end
   end

   // Tracked statistics.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NF; k++) begin
            means_ff[k] <= '0;
            var_ff[k]   <= DW'(emacv_pkg::FLOOR_RESET);
            std_ff[k]   <= emacv_pkg::STD_RESET;
            for (int m = 0; m < NF; m++) begin
               cov_ff[k][m] <= '0;
            end
         end
      end else begin
         if (mean_we) begin
            means_ff[i_ff] <= mean_in;
         end
         if (var_we) begin
            var_ff[i_ff] <= var_in;
         end
         if (std_we) begin
            std_ff[i_ff] <= sqrt_root;
         end
         if (cov_we) begin
            cov_ff[i_ff][j_ff] <= cov_in;
         end
         if (row_we) begin
            for (int k = 0; k < NF; k++) begin
               cov_ff[i_ff][k] <= x_ff[k];
            end
         end
      end
   end

   // Handshake outputs and result payload.
   assign req_ch.ready = (state_ff == emacv_pkg::ST_IDLE);
   assign rsp_ch.valid = (state_ff == emacv_pkg::ST_EMIT);
   assign fill = (status_ff == emacv_pkg::STAT_UPDATED) || (status_ff == emacv_pkg::STAT_LOADED);

   assign rsp_ch.status      = status_ff;
   assign rsp_ch.row_number  = i_ff;
   assign rsp_ch.mean_value  = fill ? means_ff[i_ff] : '0;
   assign rsp_ch.std_dev     = fill ? DW'(std_ff[i_ff]) : '0;
   assign rsp_ch.cov_0       = fill ? cov_ff[i_ff][0] : '0;
   assign rsp_ch.cov_1       = fill ? cov_ff[i_ff][1] : '0;
   assign rsp_ch.cov_2       = fill ? cov_ff[i_ff][2] : '0;
   assign rsp_ch.cov_3       = fill ? cov_ff[i_ff][3] : '0;
   assign rsp_ch.inverse_due = due_ff;
   assign rsp_ch.last        = rsp_last;

   // A request is never taken while results are being delivered.
   assert property (@(posedge clock) disable iff (reset) req_ch.ready |-> !rsp_ch.valid)
      else $error("request accepted while results pending");

   // Every accepted request makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_acc |=> !req_ch.ready)
      else $error("block still ready after accepting a request");

   // The inverse flag only rides on update results.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.inverse_due) |-> (rsp_ch.status == emacv_pkg::STAT_UPDATED))
      else $error("inverse flag on a result that is not an update");

   // Readiness implies every row has been loaded.
   assert property (@(posedge clock) disable iff (reset) rdy_ff |-> (rows_ff == '1))
      else $error("tracker ready before all rows were loaded");

endmodule

`default_nettype wire

/* sv/emacv_mul.sv */
// Shared registered 33 by 33 signed multiplier.
`default_nettype none

module emacv_mul (
   input  wire logic                                 clock,
   input  wire logic signed [emacv_pkg::OPD_W-1:0]   op_a,
   input  wire logic signed [emacv_pkg::OPD_W-1:0]   op_b,
   output logic signed [emacv_pkg::PROD_W-1:0]       prod
);

   logic signed [emacv_pkg::PROD_W-1:0] prod_ff;
   logic signed [emacv_pkg::PROD_W-1:0] prod_in;

   // Full-width product of the two operands.
   assign prod_in = emacv_pkg::PROD_W'(op_a) * emacv_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* sv/emacv_sqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none

module emacv_sqrt (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [emacv_pkg::SQRT_IN_W-1:0]       radicand,
   output logic                                       done,
   output logic [emacv_pkg::STD_W-1:0]                root
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [4:0]                          cnt_ff, cnt_in;
   logic [emacv_pkg::SQRT_IN_W-1:0]     x_ff, x_in;
   logic [emacv_pkg::STD_W:0]           rem_ff, rem_in;
   logic [emacv_pkg::STD_W-1:0]         root_ff, root_in;
   logic [emacv_pkg::STD_W+2:0]         rem_try;
   logic [emacv_pkg::STD_W+2:0]         trial;
   logic [emacv_pkg::STD_W+2:0]         rem_sub;

   // One digit step: bring down two bits and try to subtract 4*root+1.
   always_comb begin
      rem_try = {rem_ff, x_ff[emacv_pkg::SQRT_IN_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rem_sub = rem_try - trial;
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = 5'(emacv_pkg::STD_W - 1);
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in = {x_ff[emacv_pkg::SQRT_IN_W-3:0], 2'b00};
         if (rem_try >= trial) begin
            rem_in  = rem_sub[emacv_pkg::STD_W:0];
            root_in = {root_ff[emacv_pkg::STD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_try[emacv_pkg::STD_W:0];
            root_in = {root_ff[emacv_pkg::STD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

   // Once finished, the unit stays idle until the next start.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("square root finished while still busy");

endmodule

`default_nettype wire

/* sv/emacv_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module emacv_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [emacv_pkg::DIV_W-1:0]       dividend,
   input  wire logic [emacv_pkg::STD_W-1:0]       divisor,
   output logic                                   done,
   output logic [emacv_pkg::DIV_W-1:0]            quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [5:0]                        cnt_ff, cnt_in;
   logic [emacv_pkg::DIV_W-1:0]       num_ff, num_in;
   logic [emacv_pkg::STD_W-1:0]       den_ff, den_in;
   logic [emacv_pkg::STD_W-1:0]       rem_ff, rem_in;
   logic [emacv_pkg::STD_W:0]         rem_try;
   logic [emacv_pkg::STD_W:0]         rem_sub;

   // Shift in the next dividend bit; the quotient bit shifts into the dividend register.
   always_comb begin
      rem_try = {rem_ff, num_ff[emacv_pkg::DIV_W-1]};
      rem_sub = rem_try - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = 6'(emacv_pkg::DIV_W - 1);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_try >= {1'b0, den_ff}) begin
            rem_in = rem_sub[emacv_pkg::STD_W-1:0];
            num_in = {num_ff[emacv_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_try[emacv_pkg::STD_W-1:0];
            num_in = {num_ff[emacv_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

   // The partial remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench of the mean, variance and standardized covariance tracker.
module testbench;

   // One request and one result, at the block's widths.
   typedef struct packed {
      logic             func;
      logic             is_normal;
      logic [3:0][31:0] feature;
      logic [1:0]       row_index;
      logic [31:0]      init_mean;
      logic [31:0]      init_std;
   } tracker_request_type;

   typedef struct packed {
      emacv_pkg::status_type status;
      logic [1:0]       row_number;
      logic [31:0]      mean_value;
      logic [31:0]      std_dev;
      logic [3:0][31:0] cov;
      logic             inverse_due;
      logic             last;
   } tracker_result_type;

   typedef struct packed {
      tracker_request_type request;
      logic                typed;
      tracker_result_type  result;
   } directed_row_type;

   logic clock;
   logic reset;

   emacv_req_if req_ch ();
   emacv_rsp_if rsp_ch ();
   emacv_csr_if csr_ch ();

   ema_mean_variance_covariance_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Own copy of the tracker state and its registers.
   logic [15:0] rate_q16;
   logic [7:0]  interval_reg;
   logic [15:0] floor_reg;
   int          row_means [4];
   logic [31:0] row_vars [4];
   int          cov_matrix [16];
   logic [7:0]  update_cnt;
   logic [3:0]  rows_seen;
   logic        baseline_ready;

   tracker_result_type expected_results [$];
   int                 error_count;
   logic               hold_rsp;
   int                 burst_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 2000000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Fixed-point helpers of the predictor.
   function automatic longint round_shift(longint v, int s);
      logic        neg;
      logic [63:0] mag;
      neg = v < 0;
      mag = neg ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] std_from_var(logic [31:0] v);
      return 32'(int_sqrt(64'(v) << 16));
   endfunction

   function automatic logic [31:0] square_q16(logic [63:0] mag);
      logic [63:0] sq;
      if (mag >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
      sq = (mag * mag + 64'h8000) >> 16;
      return (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
   endfunction

   function automatic logic [31:0] floored_var(longint v);
      longint lim;
      lim = (floor_reg == 0) ? 1 : longint'(floor_reg);
      if (v > 64'sh FFFF_FFFF) v = 64'sh FFFF_FFFF;
      if (v < lim) v = lim;
      return v[31:0];
   endfunction

   function automatic tracker_result_type make_result(emacv_pkg::status_type st,
                                                      logic [1:0] row,
                                                      logic [31:0] mean, logic [31:0] sd,
                                                      logic [3:0][31:0] cov, logic due);
      tracker_result_type r;
      r.status      = st;
      r.row_number  = row;
      r.mean_value  = mean;
      r.std_dev     = sd;
      r.cov         = cov;
      r.inverse_due = due;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic tracker_result_type row_report(emacv_pkg::status_type st, int row,
                                                     logic due, logic last);
      tracker_result_type r;
      r.status      = st;
      r.row_number  = row[1:0];
      r.mean_value  = row_means[row];
      r.std_dev     = std_from_var(row_vars[row]);
      for (int j = 0; j < 4; j++) r.cov[j] = cov_matrix[row * 4 + j];
      r.inverse_due = due;
      r.last        = last;
      return r;
   endfunction

   // Advance the baseline by one accepted request and queue the results it causes.
   function automatic void advance_baseline(tracker_request_type q);
      longint      x [4];
      longint      dev_vals [4];
      longint      zs [4];
      longint      lr;
      longint      d;
      longint      v;
      longint      c;
      longint      ic;
      logic [63:0] mag;
      logic [63:0] sd;
      logic [63:0] quo;
      logic        due;
      int          r;
      lr = longint'(rate_q16);
      for (int i = 0; i < 4; i++) x[i] = longint'($signed(q.feature[i]));
      if (q.func) begin
         r = q.row_index;
         row_means[r] = q.init_mean;
         row_vars[r] = floored_var(longint'(square_q16(64'(q.init_std))));
         for (int j = 0; j < 4; j++) cov_matrix[r * 4 + j] = int'(x[j]);
         rows_seen[r] = 1'b1;
         if (rows_seen == 4'hF) baseline_ready = 1'b1;
         update_cnt = 0;
         expected_results.push_back(row_report(emacv_pkg::STAT_LOADED, r, 1'b0, 1'b1));
         return;
      end
      if (!baseline_ready || !q.is_normal) begin
         expected_results.push_back(make_result(baseline_ready ? emacv_pkg::STAT_SKIPPED :
                                                emacv_pkg::STAT_NOT_READY, 0, 0, 0, '0,
                                                1'b0));
         return;
      end
      // Means first, then variances against the new means.
      for (int i = 0; i < 4; i++) begin
         d = x[i] - longint'(row_means[i]);
         row_means[i] = int'(clamp32(longint'(row_means[i]) + round_shift(lr * d, 16)));
      end
      for (int i = 0; i < 4; i++) begin
         d = x[i] - longint'(row_means[i]);
         mag = (d < 0) ? 64'(-d) : 64'(d);
         v = longint'(row_vars[i]);
         dev_vals[i] = d;
         row_vars[i] = floored_var(v + round_shift(lr * (longint'(square_q16(mag)) - v),
                                                   16));
      end
      // Standardized distances in Q8.24.
      for (int i = 0; i < 4; i++) begin
         sd = 64'(std_from_var(row_vars[i]));
         mag = (dev_vals[i] < 0) ? 64'(-dev_vals[i]) : 64'(dev_vals[i]);
         quo = ((mag << 24) + (sd >> 1)) / sd;
         if (quo > 64'h8000_0000) quo = 64'h8000_0000;
         zs[i] = clamp32((dev_vals[i] < 0) ? -longint'(quo) : longint'(quo));
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            ic = clamp32(round_shift(zs[i] * zs[j], 24));
            c = longint'(cov_matrix[i * 4 + j]);
            cov_matrix[i * 4 + j] = int'(clamp32(c + round_shift(lr * (ic - c), 16)));
         end
      end
      update_cnt = update_cnt + 8'd1;
      due = 1'b0;
      if (update_cnt >= interval_reg) begin
         due = 1'b1;
         update_cnt = 0;
      end
      for (int i = 0; i < 4; i++)
         expected_results.push_back(row_report(emacv_pkg::STAT_UPDATED, i, due, i == 3));
   endfunction

   // Feature values mostly near the tracked mean, sometimes anywhere.
   function automatic logic [31:0] random_feature(int center);
      if ($urandom_range(0, 9) < 7)
         return 32'(center + int'($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
      return $urandom;
   endfunction

   function automatic tracker_request_type random_request();
      tracker_request_type q;
      q.func      = ($urandom_range(0, 99) < 12);
      q.is_normal = ($urandom_range(0, 9) != 0);
      q.row_index = $urandom_range(0, 3);
      q.init_mean = ($urandom_range(0, 3) == 0) ? $urandom : random_feature(0);
      q.init_std  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40000);
      for (int i = 0; i < 4; i++) begin
         if (q.func)
            q.feature[i] = ($urandom_range(0, 3) == 0) ? $urandom :
                           32'($urandom_range(0, 32'h2000000)) - 32'h1000000;
         else
            q.feature[i] = random_feature(row_means[i]);
      end
      return q;
   endfunction

   // Register write on the control port, taken at a handshake; valid then drops before the next write.
   task automatic program_register(logic [emacv_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         emacv_pkg::CSR_LEARNING_RATE:    rate_q16 = value;
         emacv_pkg::CSR_INVERSE_INTERVAL: interval_reg = value[7:0];
         emacv_pkg::CSR_VARIANCE_FLOOR:   floor_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one request in bursts with gaps; returns at the accepting edge.
   task automatic send_request(tracker_request_type q);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.func      <= q.func;
      req_ch.is_normal <= q.is_normal;
      req_ch.feature_0 <= q.feature[0];
      req_ch.feature_1 <= q.feature[1];
      req_ch.feature_2 <= q.feature[2];
      req_ch.feature_3 <= q.feature[3];
      req_ch.row_index <= q.row_index;
      req_ch.init_mean <= q.init_mean;
      req_ch.init_std  <= q.init_std;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle_and_configure(logic [15:0] lr, logic [15:0] ivl, logic [15:0] flr);
      req_ch.valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (40) @(posedge clock);
      program_register(emacv_pkg::CSR_LEARNING_RATE, lr);
      program_register(emacv_pkg::CSR_INVERSE_INTERVAL, ivl);
      program_register(emacv_pkg::CSR_VARIANCE_FLOOR, flr);
   endtask

   // Result side: stretches of random stalls, free stretches, and one long hold-off.
   initial begin
      int  seg_left;
      logic stalling;
      seg_left = 0;
      stalling = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (seg_left == 0) begin
               stalling = $urandom_range(0, 1);
               seg_left = $urandom_range(5, 200);
            end
            seg_left--;
            rsp_ch.ready <= stalling ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      tracker_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding, status %0d", rsp_ch.status);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_ch.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.row_number !== e.row_number) begin
               $error("row_number: expected %0d, actual %0d", e.row_number,
                      rsp_ch.row_number);
               error_count++;
            end
            if (rsp_ch.mean_value !== e.mean_value) begin
               $error("mean_value: expected %h, actual %h", e.mean_value, rsp_ch.mean_value);
               error_count++;
            end
            if (rsp_ch.std_dev !== e.std_dev) begin
               $error("std_dev: expected %h, actual %h", e.std_dev, rsp_ch.std_dev);
               error_count++;
            end
            if (rsp_ch.cov_0 !== e.cov[0]) begin
               $error("cov_0: expected %h, actual %h", e.cov[0], rsp_ch.cov_0);
               error_count++;
            end
            if (rsp_ch.cov_1 !== e.cov[1]) begin
               $error("cov_1: expected %h, actual %h", e.cov[1], rsp_ch.cov_1);
               error_count++;
            end
            if (rsp_ch.cov_2 !== e.cov[2]) begin
               $error("cov_2: expected %h, actual %h", e.cov[2], rsp_ch.cov_2);
               error_count++;
            end
            if (rsp_ch.cov_3 !== e.cov[3]) begin
               $error("cov_3: expected %h, actual %h", e.cov[3], rsp_ch.cov_3);
               error_count++;
            end
            if (rsp_ch.inverse_due !== e.inverse_due) begin
               $error("inverse_due: expected %b, actual %b", e.inverse_due,
                      rsp_ch.inverse_due);
               error_count++;
            end
            if (rsp_ch.last !== e.last) begin
               $error("last: expected %b, actual %b", e.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, then random phases over several settings.
   initial begin
      directed_row_type    plan [$];
      directed_row_type    row;
      tracker_request_type q;
      int                  before_cnt;
      logic [15:0]         phase_lr [5];
      logic [15:0]         phase_ivl [5];
      logic [15:0]         phase_flr [5];

      error_count    = 0;
      hold_rsp       = 1'b0;
      burst_left     = 0;
      rate_q16       = emacv_pkg::LR_RESET;
      interval_reg   = emacv_pkg::INTERVAL_RESET;
      floor_reg      = emacv_pkg::FLOOR_RESET;
      update_cnt     = 0;
      rows_seen      = 0;
      baseline_ready = 1'b0;
      for (int i = 0; i < 4; i++) begin
         row_means[i] = 0;
         row_vars[i] = 1;
      end
      for (int i = 0; i < 16; i++) cov_matrix[i] = 0;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func <= 1'b0;
      req_ch.is_normal <= 1'b0;
      req_ch.feature_0 <= '0;
      req_ch.feature_1 <= '0;
      req_ch.feature_2 <= '0;
      req_ch.feature_3 <= '0;
      req_ch.row_index <= '0;
      req_ch.init_mean <= '0;
      req_ch.init_std  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_register(emacv_pkg::CSR_LEARNING_RATE, emacv_pkg::LR_RESET);
      program_register(emacv_pkg::CSR_INVERSE_INTERVAL, 16'(emacv_pkg::INTERVAL_RESET));
      program_register(emacv_pkg::CSR_VARIANCE_FLOOR, emacv_pkg::FLOOR_RESET);

      // Samples before the baseline is complete are ignored.
      row = '0;
      row.request.is_normal = 1'b1;
      row.typed = 1'b1;
      row.result = make_result(emacv_pkg::STAT_NOT_READY, 0, 0, 0, '0, 1'b0);
      plan.push_back(row);
      row.request.is_normal = 1'b0;
      row.request.feature = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
      plan.push_back(row);
      // Row with the largest mean and unit std dev.
      row = '0;
      row.request.func = 1'b1;
      row.request.is_normal = 1'b1;
      row.request.feature = {32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0100_0000};
      row.request.init_mean = 32'h7FFF_FFFF;
      row.request.init_std = 32'h0001_0000;
      row.typed = 1'b1;
      row.result = make_result(emacv_pkg::STAT_LOADED, 0, 32'h7FFF_FFFF, 32'h0001_0000,
                               row.request.feature, 1'b0);
      plan.push_back(row);
      // Zero std dev falls to the floor of one, whose root is 256.
      row.request.row_index = 2'd1;
      row.request.is_normal = 1'b0;
      row.request.feature = {32'h0080_0000, 32'h1, 32'h0, 32'hFFFF_FFFF};
      row.request.init_mean = 32'h8000_0000;
      row.request.init_std = 32'h0;
      row.result = make_result(emacv_pkg::STAT_LOADED, 1, 32'h8000_0000, 32'd256,
                               row.request.feature, 1'b0);
      plan.push_back(row);
      // Largest std dev saturates the variance.
      row.typed = 1'b0;
      row.request.row_index = 2'd2;
      row.request.init_mean = 32'h0;
      row.request.init_std = 32'hFFFF_FFFF;
      plan.push_back(row);
      row = '0;
      row.request.is_normal = 1'b1;
      row.typed = 1'b1;
      row.result = make_result(emacv_pkg::STAT_NOT_READY, 0, 0, 0, '0, 1'b0);
      plan.push_back(row);
      row = '0;
      row.request.func = 1'b1;
      row.request.row_index = 2'd3;
      row.request.init_mean = 32'h0003_0000;
      row.request.init_std = 32'h0000_8000;
      row.request.feature = {32'h0100_0000, 32'h0, 32'h0, 32'h0};
      plan.push_back(row);
      // Baseline is ready: a sample that is not normal is skipped.
      row = '0;
      row.typed = 1'b1;
      row.result = make_result(emacv_pkg::STAT_SKIPPED, 0, 0, 0, '0, 1'b0);
      plan.push_back(row);
      // Normal samples at the field extremes.
      row = '0;
      row.request.is_normal = 1'b1;
      row.request.feature = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
      plan.push_back(row);
      row.request.feature = {32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      plan.push_back(row);
      row.request.feature = '0;
      plan.push_back(row);
      row.request.feature = {32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h1};
      plan.push_back(row);
      // Reloading a row after ready keeps the baseline ready.
      row = '0;
      row.request.func = 1'b1;
      row.request.is_normal = 1'b1;
      row.request.row_index = 2'd1;
      row.request.init_mean = 32'hFFFE_0000;
      row.request.init_std = 32'h0002_0000;
      row.request.feature = {32'h0, 32'h0, 32'h0100_0000, 32'hFF00_0000};
      plan.push_back(row);
      row = '0;
      row.request.is_normal = 1'b1;
      row.request.feature = {32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0003_0000};
      plan.push_back(row);
      plan.push_back(row);

      foreach (plan[k]) begin
         send_request(plan[k].request);
         before_cnt = expected_results.size();
         advance_baseline(plan[k].request);
         if (plan[k].typed) begin
            while (expected_results.size() > before_cnt) void'(expected_results.pop_back());
            expected_results.push_back(plan[k].result);
         end
      end

      // Settings per random phase, extremes and the zero cases among them.
      phase_lr  = '{16'd65535, 16'd1, 16'd4000, 16'd20000, 16'($urandom_range(1, 65535))};
      phase_ivl = '{16'd1, 16'd255, 16'd0, 16'd3, 16'($urandom_range(1, 255))};
      phase_flr = '{16'd65535, 16'd1, 16'd0, 16'd300, 16'($urandom_range(1, 65535))};
      for (int p = 0; p < 5; p++) begin
         settle_and_configure(phase_lr[p], phase_ivl[p], phase_flr[p]);
         for (int n = 0; n < 70; n++) begin
            if (p == 0 && n == 10) hold_rsp = 1'b1;
            q = random_request();
            send_request(q);
            advance_baseline(q);
         end
      end
      req_ch.valid <= 1'b0;

      wait (expected_results.size() == 0);
      repeat (500) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
sv/emacv_pkg.sv
sv/emacv_ifs.sv
sv/emacv_mul.sv
sv/emacv_sqrt.sv
sv/emacv_div.sv
sv/ema_mean_variance_covariance_tracker.sv
verif/testbench.sv
